/* hdl/tka_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the triangle normal and kis apex unit.
// No dependencies.
package tka_pkg;

  typedef struct packed {
    logic signed [23:0] vertex_a_x;
    logic signed [23:0] vertex_a_y;
    logic signed [23:0] vertex_a_z;
    logic signed [23:0] vertex_b_x;
    logic signed [23:0] vertex_b_y;
    logic signed [23:0] vertex_b_z;
    logic signed [23:0] vertex_c_x;
    logic signed [23:0] vertex_c_y;
    logic signed [23:0] vertex_c_z;
  } tka_in_t;

  typedef struct packed {
    logic signed [23:0] apex_x;
    logic signed [23:0] apex_y;
    logic signed [23:0] apex_z;
    logic signed [15:0] unit_normal_x;
    logic signed [15:0] unit_normal_y;
    logic signed [15:0] unit_normal_z;
    logic               degenerate;
  } tka_out_t;

  // Side data that rides along the normalization pipeline.
  typedef struct packed {
    logic [2:0][25:0] sum;
    logic [2:0]       neg;
    logic             degen;
  } tka_tag_t;

  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 15;

  localparam logic [5:0]         NORM_POS   = 6'd29;
  localparam logic [14:0]        UNIT_ONE   = 15'd16384;
  localparam logic [41:0]        ROUND_BIAS = 42'd24576;
  localparam logic [31:0]        RECIP3     = 32'hAAAAAAAB;
  localparam logic signed [28:0] COORD_MAX  = 29'sd8388607;
  localparam logic signed [28:0] COORD_MIN  = -29'sd8388608;

endpackage

/* hdl/triangle_kis_apex_unit.sv */
`timescale 1ns / 1ps
// Triangle unit normal and kis apex, fully pipelined.
// Depends on tka_pkg.
//
// Usage:
//   Input: a triangle transaction is taken on each rising edge with start high
//   and busy low. busy stays low, so one triangle can enter every cycle.
//   Output: done is high for one cycle with the matching result; the receiver
//   must take it then, as the pipeline never holds.
//   Config: apex_height is written over cfg_valid/cfg_ready/cfg_data; ready
//   is always high. Write it only while no triangle is in flight.
// Throughput: one triangle per cycle. The depth is set by the square root
//   (one root bit per stage, 31 stages) followed by the normal divider (one
//   quotient bit per stage, 15 stages), plus front end cross product and apex
//   rounding stages.
// Reset: rst clears the pipeline valid bits and sets apex_height to zero;
//   results in flight are dropped.
module triangle_kis_apex_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tka_pkg::tka_in_t triangle,
  output logic             done,
  output tka_pkg::tka_out_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [23:0]      cfg_data
);
  import tka_pkg::*;

  logic signed [23:0] apex_height;
  logic signed [23:0] va [3];
  logic signed [23:0] vb [3];
  logic signed [23:0] vc [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      apex_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      apex_height <= cfg_data;
    end
  end

  always_comb begin
    va[0] = triangle.vertex_a_x; va[1] = triangle.vertex_a_y; va[2] = triangle.vertex_a_z;
    vb[0] = triangle.vertex_b_x; vb[1] = triangle.vertex_b_y; vb[2] = triangle.vertex_b_z;
    vc[0] = triangle.vertex_c_x; vc[1] = triangle.vertex_c_y; vc[2] = triangle.vertex_c_z;
  end

  // stage 1: edges and coordinate sums
  logic               v1;
  logic signed [24:0] e1 [3];
  logic signed [24:0] e2 [3];
  tka_tag_t           t1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
    for (int j = 0; j < 3; j++) begin
      e1[j]     <= 25'(vb[j]) - 25'(va[j]);
      e2[j]     <= 25'(vc[j]) - 25'(va[j]);
      t1.sum[j] <= 26'(va[j]) + 26'(vb[j]) + 26'(vc[j]);
    end
    t1.neg   <= '0;
    t1.degen <= 1'b0;
  end

  // stage 2: partial products
  logic               v2;
  logic signed [49:0] pr [6];
  tka_tag_t           t2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    pr[0] <= e1[1] * e2[2];
    pr[1] <= e1[2] * e2[1];
    pr[2] <= e1[2] * e2[0];
    pr[3] <= e1[0] * e2[2];
    pr[4] <= e1[0] * e2[1];
    pr[5] <= e1[1] * e2[0];
    t2    <= t1;
  end

  // stage 3: cross product magnitudes and signs
  logic               v3;
  logic signed [50:0] cr [3];
  logic signed [50:0] crm [3];
  logic [49:0]        w3 [3];
  tka_tag_t           t3;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cr[j]  = 51'(pr[2*j]) - 51'(pr[2*j+1]);
      crm[j] = cr[j][50] ? -cr[j] : cr[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    for (int j = 0; j < 3; j++) begin
      w3[j]     <= crm[j][49:0];
      t3.neg[j] <= cr[j][50];
    end
    t3.sum   <= t2.sum;
    t3.degen <= 1'b0;
  end

  // stage 4: leading one of the largest magnitude
  logic        v4;
  logic [49:0] orw;
  logic [5:0]  lead;
  logic [5:0]  p4;
  logic [49:0] w4 [3];
  tka_tag_t    t4;

  always_comb begin
    orw  = w3[0] | w3[1] | w3[2];
    lead = '0;
    for (int i = 0; i < 50; i++) begin
      if (orw[i]) lead = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    p4       <= lead;
    w4       <= w3;
    t4.sum   <= t3.sum;
    t4.neg   <= t3.neg;
    t4.degen <= (orw == '0);
  end

  // stage 5: normalize to [2^29, 2^30)
  logic        v5;
  logic [49:0] wsh [3];
  logic [29:0] w5 [3];
  tka_tag_t    t5;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (p4 >= NORM_POS) wsh[j] = w4[j] >> (p4 - NORM_POS);
      else                wsh[j] = w4[j] << (NORM_POS - p4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    for (int j = 0; j < 3; j++) w5[j] <= wsh[j][29:0];
    t5 <= t4;
  end

  // stage 6: squares
  logic        v6;
  logic [59:0] sqr [3];
  logic [29:0] w6 [3];
  tka_tag_t    t6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    for (int j = 0; j < 3; j++) sqr[j] <= 60'(w5[j]) * 60'(w5[j]);
    w6 <= w5;
    t6 <= t5;
  end

  // stage 7 and square root: one root bit per stage
  logic             sq_v    [0:SQ_STEPS];
  logic [61:0]      sq_s    [0:SQ_STEPS];
  logic [33:0]      sq_rem  [0:SQ_STEPS];
  logic [30:0]      sq_root [0:SQ_STEPS];
  logic [2:0][29:0] sq_w    [0:SQ_STEPS];
  tka_tag_t         sq_tag  [0:SQ_STEPS];
  logic [33:0]      sq_rs      [SQ_STEPS];
  logic [33:0]      sq_t       [SQ_STEPS];
  logic [33:0]      sq_rem_nx  [SQ_STEPS];
  logic [30:0]      sq_root_nx [SQ_STEPS];

  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_rs[k] = {sq_rem[k][31:0], sq_s[k][61-2*k -: 2]};
      sq_t[k]  = {1'b0, sq_root[k], 2'b01};
      if (sq_rs[k] >= sq_t[k]) begin
        sq_rem_nx[k]  = sq_rs[k] - sq_t[k];
        sq_root_nx[k] = {sq_root[k][29:0], 1'b1};
      end else begin
        sq_rem_nx[k]  = sq_rs[k];
        sq_root_nx[k] = {sq_root[k][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_STEPS; k++) sq_v[k] <= 1'b0;
    end else begin
      sq_v[0] <= v6;
      for (int k = 0; k < SQ_STEPS; k++) sq_v[k+1] <= sq_v[k];
    end
    sq_s[0]    <= 62'(sqr[0]) + 62'(sqr[1]) + 62'(sqr[2]);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    for (int j = 0; j < 3; j++) sq_w[0][j] <= w6[j];
    sq_tag[0]  <= t6;
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_s[k+1]    <= sq_s[k];
      sq_rem[k+1]  <= sq_rem_nx[k];
      sq_root[k+1] <= sq_root_nx[k];
      sq_w[k+1]    <= sq_w[k];
      sq_tag[k+1]  <= sq_tag[k];
    end
  end

  // normal divider: three lanes, one quotient bit per stage
  logic             dv_v   [0:DIV_STEPS];
  logic [2:0][44:0] dv_n   [0:DIV_STEPS];
  logic [2:0][30:0] dv_rem [0:DIV_STEPS];
  logic [2:0][14:0] dv_q   [0:DIV_STEPS];
  logic [30:0]      dv_r   [0:DIV_STEPS];
  tka_tag_t         dv_tag [0:DIV_STEPS];
  logic [2:0][31:0] dv_rs     [DIV_STEPS];
  logic [2:0][30:0] dv_rem_nx [DIV_STEPS];
  logic [2:0][14:0] dv_q_nx   [DIV_STEPS];
  logic [44:0]      nnum [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nnum[j] = {1'b0, sq_w[SQ_STEPS][j], 14'd0} + 45'(sq_root[SQ_STEPS][30:1]);
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int j = 0; j < 3; j++) begin
        dv_rs[k][j] = {dv_rem[k][j], dv_n[k][j][14-k]};
        if (dv_rs[k][j] >= {1'b0, dv_r[k]}) begin
          dv_rem_nx[k][j] = 31'(dv_rs[k][j] - {1'b0, dv_r[k]});
          dv_q_nx[k][j]   = {dv_q[k][j][13:0], 1'b1};
        end else begin
          dv_rem_nx[k][j] = dv_rs[k][j][30:0];
          dv_q_nx[k][j]   = {dv_q[k][j][13:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) dv_v[k] <= 1'b0;
    end else begin
      dv_v[0] <= sq_v[SQ_STEPS];
      for (int k = 0; k < DIV_STEPS; k++) dv_v[k+1] <= dv_v[k];
    end
    for (int j = 0; j < 3; j++) begin
      dv_n[0][j]   <= nnum[j];
      dv_rem[0][j] <= 31'(nnum[j][44:15]);
    end
    dv_q[0]   <= '0;
    dv_r[0]   <= sq_root[SQ_STEPS];
    dv_tag[0] <= sq_tag[SQ_STEPS];
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_n[k+1]   <= dv_n[k];
      dv_rem[k+1] <= dv_rem_nx[k];
      dv_q[k+1]   <= dv_q_nx[k];
      dv_r[k+1]   <= dv_r[k];
      dv_tag[k+1] <= dv_tag[k];
    end
  end

  // apex stage A: signed normal and height product
  tka_tag_t           tq;
  logic [14:0]        qc [3];
  logic signed [15:0] nrm [3];
  logic               vA;
  logic signed [15:0] nA [3];
  logic signed [39:0] prodA [3];
  logic signed [25:0] sumA [3];
  logic               dgA;

  always_comb begin
    tq = dv_tag[DIV_STEPS];
    for (int j = 0; j < 3; j++) begin
      qc[j] = (dv_q[DIV_STEPS][j] > UNIT_ONE) ? UNIT_ONE : dv_q[DIV_STEPS][j];
      if (tq.degen)      nrm[j] = '0;
      else if (tq.neg[j]) nrm[j] = -$signed(16'(qc[j]));
      else               nrm[j] = $signed(16'(qc[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vA <= 1'b0;
    else     vA <= dv_v[DIV_STEPS];
    for (int j = 0; j < 3; j++) begin
      nA[j]    <= nrm[j];
      prodA[j] <= apex_height * nrm[j];
      sumA[j]  <= $signed(tq.sum[j]);
    end
    dgA <= tq.degen;
  end

  // stage B: numerator
  logic               vB;
  logic signed [41:0] numB [3];
  logic signed [15:0] nB [3];
  logic               dgB;

  always_ff @(posedge clk) begin
    if (rst) vB <= 1'b0;
    else     vB <= vA;
    for (int j = 0; j < 3; j++) begin
      numB[j] <= (42'(sumA[j]) <<< 14) + 42'(prodA[j]) + (42'(prodA[j]) <<< 1);
    end
    nB  <= nA;
    dgB <= dgA;
  end

  // stage C: magnitude, bias, divide by 2^14
  logic               vC;
  logic [41:0]        magB [3];
  logic [41:0]        biasB [3];
  logic [28:0]        vqC [3];
  logic [2:0]         negC;
  logic signed [15:0] nC [3];
  logic               dgC;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      magB[j]  = numB[j][41] ? 42'(-numB[j]) : 42'(numB[j]);
      biasB[j] = (magB[j] + ROUND_BIAS) >> 14;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vC <= 1'b0;
    else     vC <= vB;
    for (int j = 0; j < 3; j++) begin
      vqC[j]  <= biasB[j][28:0];
      negC[j] <= numB[j][41];
    end
    nC  <= nB;
    dgC <= dgB;
  end

  // stage D: divide by 3 through reciprocal
  logic               vD;
  logic [60:0]        rcp [3];
  logic [27:0]        qD [3];
  logic [2:0]         negD;
  logic signed [15:0] nD [3];
  logic               dgD;

  always_comb begin
    for (int j = 0; j < 3; j++) rcp[j] = 61'(vqC[j]) * 61'(RECIP3);
  end

  always_ff @(posedge clk) begin
    if (rst) vD <= 1'b0;
    else     vD <= vC;
    for (int j = 0; j < 3; j++) qD[j] <= rcp[j][60:33];
    negD <= negC;
    nD   <= nC;
    dgD  <= dgC;
  end

  // stage E: sign, saturate, output register
  logic signed [28:0] aq [3];
  logic signed [23:0] ap [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      aq[j] = negD[j] ? -$signed({1'b0, qD[j]}) : $signed({1'b0, qD[j]});
      if (aq[j] > COORD_MAX)      ap[j] = COORD_MAX[23:0];
      else if (aq[j] < COORD_MIN) ap[j] = COORD_MIN[23:0];
      else                        ap[j] = aq[j][23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vD;
    result.apex_x        <= ap[0];
    result.apex_y        <= ap[1];
    result.apex_z        <= ap[2];
    result.unit_normal_x <= nD[0];
    result.unit_normal_y <= nD[1];
    result.unit_normal_z <= nD[2];
    result.degenerate    <= dgD;
  end

endmodule
